// ===== rtl/mba_pkg.sv =====
// Shared constants, types and helper functions of the multichannel block averager.
package mba_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int SUM_WIDTH    = 28;

    localparam int CH_W        = $clog2(MAX_CHANNELS);
    localparam int SAMPLE_W    = 16;
    localparam int AVG_W       = 16;
    localparam int LEN_W       = 13;
    localparam int CHN_W       = 7;
    localparam int SCAN_W      = 12;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_CNT_W   = $clog2(SUM_WIDTH);
    localparam int REM_W       = LEN_W + 1;

    localparam logic [LEN_W-1:0]    LENGTH_LIMIT = LEN_W'(4096);
    localparam logic [SAMPLE_W-1:0] RECENTER     = 16'h8000;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AVG_LEN = 2'd0,
        REG_CHANS   = 2'd1,
        REG_SHIP    = 2'd2
    } t_reg_idx;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // input transfer: latch sample, advance counters
        logic update;    // add sample to sum, write back sum (or zero at period end), load divider
        logic div_step;  // one restoring divide step
        logic out_load;  // load the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_scan;
        logic ship;
        logic out_free;
    } t_sts;

    // Averaging length with zero taken as one and large values saturated
    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LENGTH_LIMIT) begin
            res = LENGTH_LIMIT;
        end
        return res;
    endfunction

    // Channel count with zero taken as one and large values saturated
    function automatic logic [CHN_W-1:0] eff_channels(input logic [CHN_W-1:0] chans);
        logic [CHN_W-1:0] res;
        res = chans;
        if (chans == '0) begin
            res = CHN_W'(1);
        end else if (chans > CHN_W'(MAX_CHANNELS)) begin
            res = CHN_W'(MAX_CHANNELS);
        end
        return res;
    endfunction

endpackage

// ===== rtl/mba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mba_ctrl.sv =====
// Controller state machine: sequences capture, accumulate, divide and output.
module mba_ctrl import mba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state               r_state;
    logic [DIV_CNT_W-1:0] r_cnt;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    r_cnt <= '0;
                    if (i_sts.last_scan) begin
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(SUM_WIDTH - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // drop the result when shipping is off, else wait for room
                    if (!i_sts.ship || i_sts.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Decode commands from the state
    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_cmd.capture   = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.update    = (r_state == ST_ADD);
    assign o_cmd.div_step  = (r_state == ST_DIV);
    assign o_cmd.out_load  = (r_state == ST_DONE) && i_sts.ship && i_sts.out_free;

endmodule

// ===== rtl/mba_dp.sv =====
// Datapath: configuration, counters, channel sums, divider and output register.
module mba_dp import mba_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [SAMPLE_W-1:0]  i_raw_sample,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [CH_W-1:0]      o_channel_index,
    output logic [AVG_W-1:0]     o_average_value,
    output logic                 o_last_of_block,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts
);

    logic [LEN_W-1:0]     r_avg_len;
    logic [CHN_W-1:0]     r_chans;
    logic                 r_ship;

    logic [CH_W-1:0]      r_pos;
    logic [SCAN_W-1:0]    r_scan;

    logic [SAMPLE_W-1:0]  r_sample;
    logic [CH_W-1:0]      r_item_pos;
    logic                 r_item_last_chan;
    logic                 r_item_last_scan;
    logic [LEN_W-1:0]     r_item_len;

    logic [MAX_CHANNELS-1:0] r_valid;

    logic [REM_W-1:0]     r_rem;
    logic [SUM_WIDTH-1:0] r_quo;

    logic                 r_out_valid;
    logic [CH_W-1:0]      r_out_ch;
    logic [AVG_W-1:0]     r_out_avg;
    logic                 r_out_last;

    logic [LEN_W-1:0]     w_len;
    logic [CHN_W-1:0]     w_chans;
    logic                 w_last_chan;
    logic                 w_last_scan;
    logic [SUM_WIDTH-1:0] w_rdata;
    logic [SUM_WIDTH-1:0] w_old_sum;
    logic [SUM_WIDTH-1:0] w_new_sum;
    logic [SUM_WIDTH-1:0] w_wdata;
    logic [REM_W-1:0]     w_trial;
    logic                 w_fits;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_len <= LEN_W'(1);
            r_chans   <= CHN_W'(MAX_CHANNELS);
            r_ship    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AVG_LEN: r_avg_len <= i_cfg_data[LEN_W-1:0];
                REG_CHANS:   r_chans   <= i_cfg_data[CHN_W-1:0];
                REG_SHIP:    r_ship    <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    // End-of-scan and end-of-period decisions for the current position
    assign w_len       = eff_length(r_avg_len);
    assign w_chans     = eff_channels(r_chans);
    assign w_last_chan = (({1'b0, r_pos} + CHN_W'(1)) >= w_chans);
    assign w_last_scan = (({1'b0, r_scan} + LEN_W'(1)) >= w_len);

    // Advance position and scan counters on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_scan <= '0;
        end else if (i_cmd.capture) begin
            if (w_last_chan) begin
                r_pos <= '0;
                if (w_last_scan) begin
                    r_scan <= '0;
                end else begin
                    r_scan <= r_scan + SCAN_W'(1);
                end
            end else begin
                r_pos <= r_pos + CH_W'(1);
            end
        end
    end

    // Hold the item being worked on
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample         <= i_raw_sample ^ RECENTER;
            r_item_pos       <= r_pos;
            r_item_last_chan <= w_last_chan;
            r_item_last_scan <= w_last_scan;
            r_item_len       <= w_len;
        end
    end

    // Channel sums; an entry never written since reset reads as zero
    assign w_old_sum = r_valid[r_item_pos] ? w_rdata : '0;
    assign w_new_sum = w_old_sum + SUM_WIDTH'(r_sample);
    assign w_wdata   = r_item_last_scan ? '0 : w_new_sum;

    mba_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (MAX_CHANNELS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_item_pos),
        .i_wdata (w_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.update) begin
            r_valid[r_item_pos] <= 1'b1;
        end
    end

    // Restoring divider, one quotient bit per step
    assign w_trial = {r_rem[LEN_W-1:0], r_quo[SUM_WIDTH-1]};
    assign w_fits  = (w_trial >= {1'b0, r_item_len});

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_rem <= '0;
            r_quo <= w_new_sum;
        end else if (i_cmd.div_step) begin
            r_rem <= w_fits ? (w_trial - {1'b0, r_item_len}) : w_trial;
            r_quo <= {r_quo[SUM_WIDTH-2:0], w_fits};
        end
    end

    // Output register: load a result, release it on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ch   <= r_item_pos;
            r_out_avg  <= r_quo[AVG_W-1:0];
            r_out_last <= r_item_last_chan;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_ch;
    assign o_average_value = r_out_avg;
    assign o_last_of_block = r_out_last;

    assign o_sts.last_scan = r_item_last_scan;
    assign o_sts.ship      = r_ship;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

endmodule

// ===== rtl/multichannel_block_averager.sv =====
// Top level of the multichannel block averager: controller plus datapath.
// The sum is written back in the cycle after an input transfer when no result is due;
//   at period end the add, 28 divide steps and the output load follow in that order.
// The input stalls from each accepted sample until its work is done, so a new sample
//   is taken only after the last one; on the last scan this includes the divider.
// Reset (synchronous, active low) restores the register defaults, zeroes counters
//   and marks all channel sums as zero at once.
module multichannel_block_averager import mba_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [SAMPLE_W-1:0]  i_raw_sample,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CH_W-1:0]      o_channel_index,
    output logic [AVG_W-1:0]     o_average_value,
    output logic                 o_last_of_block
);

    t_cmd w_cmd;
    t_sts w_sts;

    mba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    mba_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_raw_sample    (i_raw_sample),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_channel_index (o_channel_index),
        .o_average_value (o_average_value),
        .o_last_of_block (o_last_of_block),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts)
    );

endmodule

// ===== rtl/mba_checker.sv =====
// Port-level checker of the multichannel block averager, bound to the top level.
module mba_checker import mba_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [AVG_W-1:0]    o_average_value,
    input logic [CH_W-1:0]     o_channel_index
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_average_value) && $stable(o_channel_index))
        else $error("stalled result changed");

    // Each input transfer starts work that stalls the input in the following cycle
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while the previous sample is still in work");

    // A new result only appears at the end of an item's work
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

    // Reset leaves no result offered
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind multichannel_block_averager mba_checker u_mba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_average_value (o_average_value),
    .o_channel_index (o_channel_index)
);

// ===== sim/multichannel_block_averager_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the multichannel block averager: sample streams against a predictor.
module multichannel_block_averager_tb;
    import mba_pkg::*;

    localparam int SETTLE_CYCLES = 80;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 600;
    localparam int REPORT_LIMIT  = 200;
    localparam int HOLD_OFF      = 300;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [AVG_W-1:0] average;
        logic             last;
    } t_average;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [SAMPLE_W-1:0]  i_raw_sample;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [CH_W-1:0]      o_channel_index;
    logic [AVG_W-1:0]     o_average_value;
    logic                 o_last_of_block;

    // Predictor copy of the registers, counters and per-channel sums
    logic [LEN_W-1:0]     cur_avg_len;
    logic [CHN_W-1:0]     cur_chans;
    logic                 cur_ship;
    logic [SUM_WIDTH-1:0] acc_sums [MAX_CHANNELS];
    int unsigned          acc_pos;
    logic [SCAN_W-1:0]    acc_scan;

    t_average expected_averages[$];
    int       mismatch_count;
    int       burst_left;
    int       hold_off_cycles;
    int       idle_cycles;

    multichannel_block_averager dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_raw_sample    (i_raw_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_channel_index (o_channel_index),
        .o_average_value (o_average_value),
        .o_last_of_block (o_last_of_block)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Accumulate one sample and queue the average it completes, if any and if shipping is on
    function automatic void predict_average(input logic [SAMPLE_W-1:0] raw);
        int unsigned len;
        int unsigned chans;
        int unsigned pos;
        logic        last_chan;
        logic        last_scan;
        t_average    res;
        len = (cur_avg_len == 0) ? 1 : ((cur_avg_len > LENGTH_LIMIT) ? LENGTH_LIMIT : cur_avg_len);
        chans = (cur_chans == 0) ? 1 : ((cur_chans > MAX_CHANNELS) ? MAX_CHANNELS : cur_chans);
        pos = (acc_pos >= MAX_CHANNELS) ? MAX_CHANNELS - 1 : acc_pos;
        last_chan = (pos + 1 >= chans);
        last_scan = (int'(acc_scan) + 1 >= len);
        acc_sums[pos] = acc_sums[pos] + SUM_WIDTH'(raw ^ RECENTER);
        if (last_scan) begin
            res.channel = CH_W'(pos);
            res.average = AVG_W'(acc_sums[pos] / len);
            res.last = last_chan;
            acc_sums[pos] = '0;
            if (cur_ship) begin
                expected_averages.push_back(res);
            end
        end
        if (last_chan) begin
            acc_pos = 0;
            acc_scan = last_scan ? '0 : acc_scan + 1'b1;
        end else begin
            acc_pos = pos + 1;
        end
    endfunction

    // Mix of extreme, near-zero-point and fully random converter words
    function automatic logic [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return RECENTER;
            3: return SAMPLE_W'(RECENTER - 1);
            4: return RECENTER ^ SAMPLE_W'($urandom_range(0, 3));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one sample, hold it until transfer, then maybe insert a gap
    task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_raw_sample <= raw;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        predict_average(raw);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(64, 200)
                                                     : $urandom_range(0, 15);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 3);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_raw_sample <= SAMPLE_W'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_AVG_LEN: cur_avg_len = value[LEN_W-1:0];
            REG_CHANS:   cur_chans = value[CHN_W-1:0];
            REG_SHIP:    cur_ship = value[0];
            default: ;
        endcase
    endtask

    // Stop sending, drain every expected average, then let the block settle
    task automatic wait_for_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_ship_disabled();
        repeat (3) send_sample(draw_sample());
        wait_for_idle();
    endtask

    task automatic test_field_extremes();
        write_reg(REG_SHIP, CFG_W'(1));
        write_reg(REG_CHANS, CFG_W'(3));
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0001);
        send_sample(16'hFFFE);
        send_sample(16'h8001);
        wait_for_idle();
    endtask

    task automatic test_zero_settings();
        write_reg(REG_AVG_LEN, '0);
        write_reg(REG_CHANS, '0);
        repeat (3) send_sample(draw_sample());
        wait_for_idle();
        write_reg(REG_AVG_LEN, CFG_W'(2));
        write_reg(REG_CHANS, CFG_W'(2));
        repeat (4) send_sample(draw_sample());
        wait_for_idle();
    endtask

    // Shorten the period while a scan is partly done
    task automatic test_mid_period_write();
        write_reg(REG_AVG_LEN, CFG_W'(4));
        write_reg(REG_CHANS, CFG_W'(4));
        repeat (5) send_sample(draw_sample());
        wait_for_idle();
        write_reg(REG_AVG_LEN, CFG_W'(2));
        repeat (3) send_sample(draw_sample());
        wait_for_idle();
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase_items;
        int len_val;
        int chan_val;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_for_idle();
            case ($urandom_range(0, 9))
                0:                len_val = 0;
                1, 2, 3, 4, 5, 6: len_val = $urandom_range(1, 4);
                7, 8:             len_val = $urandom_range(5, 16);
                default:          len_val = $urandom_range(17, 40);
            endcase
            case ($urandom_range(0, 9))
                0:       chan_val = 0;
                1:       chan_val = MAX_CHANNELS;
                2:       chan_val = $urandom_range(MAX_CHANNELS + 1, 127);
                default: chan_val = $urandom_range(1, 16);
            endcase
            write_reg(REG_AVG_LEN, CFG_W'(len_val));
            write_reg(REG_CHANS, CFG_W'(chan_val));
            write_reg(REG_SHIP, CFG_W'($urandom_range(0, 7) != 0));
            phase_items = $urandom_range(20, 80);
            repeat (phase_items) send_sample(draw_sample());
            sent += phase_items;
        end
        wait_for_idle();
    endtask

    // Hold the output off long enough that the input backs up
    task automatic test_output_hold_off();
        write_reg(REG_AVG_LEN, CFG_W'(1));
        write_reg(REG_CHANS, '1);
        write_reg(REG_SHIP, CFG_W'(1));
        hold_off_cycles = HOLD_OFF;
        repeat (80) send_sample(draw_sample());
        wait_for_idle();
    endtask

    task automatic report_mismatch(input string field, input int unsigned exp_val,
                                   input int unsigned act_val);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, exp_val, act_val);
        end
    endtask

    // Compare each result transfer with the oldest expected average
    always @(posedge i_clk) begin
        t_average want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_averages.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $error("unexpected result on channel %0d", o_channel_index);
                end
            end else begin
                want = expected_averages.pop_front();
                if (o_channel_index !== want.channel) begin
                    report_mismatch("channel_index", want.channel, o_channel_index);
                end
                if (o_average_value !== want.average) begin
                    report_mismatch("average_value", want.average, o_average_value);
                end
                if (o_last_of_block !== want.last) begin
                    report_mismatch("last_of_block", want.last, o_last_of_block);
                end
            end
        end
    end

    // End the run if no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver stall pattern: free, sparse, periodic or heavy, plus requested hold-offs
    initial begin : out_stall_pattern
        int mode;
        int span;
        i_out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 200);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                if (hold_off_cycles > 0) begin
                    i_out_stall <= 1'b1;
                    hold_off_cycles--;
                end else begin
                    case (mode)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= ($urandom_range(0, 9) < 3);
                        2:       i_out_stall <= ((k % 5) >= 3);
                        default: i_out_stall <= ($urandom_range(0, 9) < 7);
                    endcase
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_AVG_LEN;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_raw_sample = '0;
        idle_cycles = 0;
        hold_off_cycles = 0;
        burst_left = 0;
        mismatch_count = 0;
        cur_avg_len = LEN_W'(1);
        cur_chans = CHN_W'(MAX_CHANNELS);
        cur_ship = 1'b0;
        acc_pos = 0;
        acc_scan = '0;
        foreach (acc_sums[i]) acc_sums[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_ship_disabled();
        test_field_extremes();
        test_zero_settings();
        test_mid_period_write();
        test_random_traffic();
        test_output_hold_off();

        wait_for_idle();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mba_pkg.sv
rtl/mba_ram.sv
rtl/mba_ctrl.sv
rtl/mba_dp.sv
rtl/multichannel_block_averager.sv
rtl/mba_checker.sv
sim/multichannel_block_averager_tb.sv
